// ===== src/rvv_pkg.sv =====
// ----------------------------------------------------------------------------
// rvv_pkg - shared types and constants
// Field widths, register indexes and divider sizes for the vol-of-vol block.
// ----------------------------------------------------------------------------
package rvv_pkg;

    localparam int PRICE_W  = 24;
    localparam int RSQ_W    = 48;
    localparam int VOL_W    = 32;
    localparam int VOV_W    = 64;
    localparam int VOLWIN_W = 11;
    localparam int VOVWIN_W = 10;
    localparam int IDX_W    = 2;

    // divider: 64-bit dividend, divisor up to 2047
    localparam int DIV_W    = 64;
    localparam int DVSR_W   = 11;
    localparam int DCNT_W   = 7;

    localparam logic [IDX_W-1:0] REG_VOL_WINDOW = 2'd0;
    localparam logic [IDX_W-1:0] REG_VOV_WINDOW = 2'd1;

    typedef logic [DIV_W-1:0] div_word_t;

endpackage

// ===== src/rvv_div.sv =====
// ----------------------------------------------------------------------------
// rvv_div - iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rvv_div
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  rvv_pkg::div_word_t              dividend,
    input  logic [rvv_pkg::DVSR_W-1:0]      divisor,
    output logic                            done,
    output rvv_pkg::div_word_t              quotient
);

    logic                           busy_reg;
    logic                           done_reg;
    logic [rvv_pkg::DCNT_W-1:0]     cnt_reg;
    rvv_pkg::div_word_t             quo_reg;
    logic [rvv_pkg::DVSR_W-1:0]     rem_reg;
    logic [rvv_pkg::DVSR_W-1:0]     dvsr_reg;
    logic [rvv_pkg::DVSR_W:0]       trial;
    logic [rvv_pkg::DVSR_W:0]       diff;
    logic                           ge;

    always_comb
    begin
        trial = {rem_reg, quo_reg[rvv_pkg::DIV_W-1]};
        diff  = trial - {1'b0, dvsr_reg};
        ge    = (trial >= {1'b0, dvsr_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= rvv_pkg::DCNT_W'(rvv_pkg::DIV_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == rvv_pkg::DCNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg  <= dividend;
            rem_reg  <= '0;
            dvsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[rvv_pkg::DIV_W-2:0], ge};
            rem_reg <= ge ? diff[rvv_pkg::DVSR_W-1:0] : trial[rvv_pkg::DVSR_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== src/rolling_vol_of_vol.sv =====
// ----------------------------------------------------------------------------
// rolling_vol_of_vol - rolling volatility of volatility
// Squared-return ring, volatility history ring and a sequencer that runs
// read passes through one accumulator and divides on a shared divider.
// ----------------------------------------------------------------------------
//  channel  | dir | signals                                  | word
//  s_       | in  | s_tvalid s_tready s_tdata[23:0]          | close_price
//  m_       | out | m_tvalid m_tready m_tuser m_tdata        | vov_valid, vov
//  cfg_     | in  | cfg_valid cfg_ready cfg_index cfg_data   | register write
//
//  A full bar (n = min(w, returns held), w and v the effective windows) runs
//  one pass over n return slots and two over v history values, and three
//  divides from accept to result; the last divide is skipped on saturation.
//  Early bars skip the passes; bars with short history stop after the first
//  divide.
//  s_tready is high only while the sequencer is idle; a finished bar holds
//  while the output register is full and m_tready is low.
//  No clearing pass after reset: unwritten return slots are masked by a fill
//  count. cfg_ready is always high.
// ----------------------------------------------------------------------------
module rolling_vol_of_vol
#(
    parameter int HISTORY_DEPTH = 1024,
    parameter int PRICE_BITS    = 24
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rvv_pkg::PRICE_W-1:0]     s_tdata,    // [23:0] close_price
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic                            m_tuser,    // [0] vov_valid
    output logic [rvv_pkg::VOV_W-1:0]       m_tdata,    // [63:0] vov
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rvv_pkg::IDX_W-1:0]       cfg_index,
    input  logic [rvv_pkg::VOLWIN_W-1:0]    cfg_data
);

    localparam int AW    = $clog2(HISTORY_DEPTH);
    localparam int CW    = $clog2(HISTORY_DEPTH + 1);
    localparam int CMP_W = 13;
    localparam int PB    = (PRICE_BITS < rvv_pkg::PRICE_W) ? PRICE_BITS : rvv_pkg::PRICE_W;
    localparam logic [rvv_pkg::PRICE_W-1:0] PRICE_MASK =
        rvv_pkg::PRICE_W'((33'd1 << PB) - 33'd1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(HISTORY_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(HISTORY_DEPTH);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_RET  = 4'd1;
    localparam logic [3:0] ST_RSUM = 4'd2;
    localparam logic [3:0] ST_DIV1 = 4'd3;
    localparam logic [3:0] ST_WVOL = 4'd4;
    localparam logic [3:0] ST_MSUM = 4'd5;
    localparam logic [3:0] ST_DIV2 = 4'd6;
    localparam logic [3:0] ST_DEV  = 4'd7;
    localparam logic [3:0] ST_DIV3 = 4'd8;
    localparam logic [3:0] ST_DONE = 4'd9;

    logic [3:0]                         state_reg, state_next;
    logic [rvv_pkg::VOLWIN_W-1:0]       vol_win_reg;
    logic [rvv_pkg::VOVWIN_W-1:0]       vov_win_reg;
    logic [rvv_pkg::PRICE_W-1:0]        price_reg, prev_reg;
    logic [1:0]                         bar_cnt_reg;
    logic [AW-1:0]                      rptr_reg, vptr_reg;
    logic [CW-1:0]                      rs_cnt_reg, vcnt_reg;
    logic [CW-1:0]                      left_reg;
    logic [AW-1:0]                      addr_reg;
    logic                               p1_reg, p2_reg;
    logic [rvv_pkg::VOV_W-1:0]          val_reg, acc_reg;
    logic                               sat_reg;
    logic [rvv_pkg::VOL_W-1:0]          mean_reg;
    logic                               res_valid_reg;
    logic [rvv_pkg::VOV_W-1:0]          res_reg;
    logic                               m_tvalid_reg, m_tuser_reg;
    logic [rvv_pkg::VOV_W-1:0]          m_tdata_reg;

    logic [rvv_pkg::RSQ_W-1:0]          rs_mem [HISTORY_DEPTH];
    logic [rvv_pkg::VOL_W-1:0]          vh_mem [HISTORY_DEPTH];
    logic [rvv_pkg::RSQ_W-1:0]          rs_rdata_reg;
    logic [rvv_pkg::VOL_W-1:0]          vh_rdata_reg;

    logic                               accept;
    logic [rvv_pkg::PRICE_W-1:0]        ret_diff;
    logic [rvv_pkg::RSQ_W-1:0]          ret_sq;
    logic [CMP_W-1:0]                   wc, vc;
    logic [CW-1:0]                      rs_cnt_new, vcnt_new;
    logic [CW-1:0]                      n_rsum;
    logic                               pass_state, pass_end, rd_en;
    logic [rvv_pkg::VOL_W-1:0]          dev;
    logic [rvv_pkg::VOV_W-1:0]          dev_sq;
    logic [rvv_pkg::VOV_W:0]            acc_sum;
    logic                               div_start, div_done;
    rvv_pkg::div_word_t                 div_q;
    logic [rvv_pkg::DVSR_W-1:0]         div_dvsr;
    logic [rvv_pkg::VOL_W-1:0]          vol_sat;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tuser   = m_tuser_reg;
    assign m_tdata   = m_tdata_reg;

    always_comb
    begin
        ret_diff = (price_reg >= prev_reg) ? price_reg - prev_reg : prev_reg - price_reg;
        ret_sq   = rvv_pkg::RSQ_W'(ret_diff) * rvv_pkg::RSQ_W'(ret_diff);

        if (vol_win_reg == '0)
            wc = CMP_W'(1);
        else if (CMP_W'(vol_win_reg) > CMP_W'(HISTORY_DEPTH))
            wc = CMP_W'(HISTORY_DEPTH);
        else
            wc = CMP_W'(vol_win_reg);
        vc = (vov_win_reg == '0) ? CMP_W'(1) : CMP_W'(vov_win_reg);

        rs_cnt_new = (rs_cnt_reg == DEPTH_CNT) ? rs_cnt_reg : rs_cnt_reg + 1'b1;
        vcnt_new   = (vcnt_reg == DEPTH_CNT) ? vcnt_reg : vcnt_reg + 1'b1;
        n_rsum     = (CMP_W'(rs_cnt_new) < wc) ? rs_cnt_new : CW'(wc);

        pass_state = (state_reg == ST_RSUM) || (state_reg == ST_MSUM)
                     || (state_reg == ST_DEV);
        rd_en      = pass_state && (left_reg != '0);
        pass_end   = pass_state && (left_reg == '0) && !p1_reg && !p2_reg;

        dev     = (vh_rdata_reg >= mean_reg) ? vh_rdata_reg - mean_reg
                                             : mean_reg - vh_rdata_reg;
        dev_sq  = rvv_pkg::VOV_W'(dev) * rvv_pkg::VOV_W'(dev);
        acc_sum = {1'b0, acc_reg} + {1'b0, val_reg};

        vol_sat = (div_q[rvv_pkg::DIV_W-1:rvv_pkg::VOL_W] != '0)
                  ? '1 : div_q[rvv_pkg::VOL_W-1:0];
        div_dvsr = (state_reg == ST_DEV || state_reg == ST_MSUM)
                   ? rvv_pkg::DVSR_W'(vc) : rvv_pkg::DVSR_W'(wc);
        // at pass end the last add has landed; only the sticky flag counts
        div_start = pass_end && !(state_reg == ST_DEV && sat_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_RET;
            ST_RET:  state_next = (bar_cnt_reg == 2'd3) ? ST_RSUM : ST_DONE;
            ST_RSUM: if (pass_end) state_next = ST_DIV1;
            ST_DIV1: if (div_done) state_next = ST_WVOL;
            ST_WVOL: state_next = (CMP_W'(vcnt_new) < vc + CMP_W'(1)) ? ST_DONE : ST_MSUM;
            ST_MSUM: if (pass_end) state_next = ST_DIV2;
            ST_DIV2: if (div_done) state_next = ST_DEV;
            ST_DEV:  if (pass_end) state_next = div_start ? ST_DIV3 : ST_DONE;
            ST_DIV3: if (div_done) state_next = ST_DONE;
            ST_DONE: if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    rvv_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_reg),
        .divisor  (div_dvsr),
        .done     (div_done),
        .quotient (div_q)
    );

    // ring memories: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RET && bar_cnt_reg != 2'd0)
            rs_mem[rptr_reg] <= ret_sq;
        if (state_reg == ST_WVOL)
            vh_mem[vptr_reg] <= vol_sat;
        rs_rdata_reg <= rs_mem[addr_reg];
        vh_rdata_reg <= vh_mem[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            vol_win_reg   <= rvv_pkg::VOLWIN_W'(30);
            vov_win_reg   <= rvv_pkg::VOVWIN_W'(30);
            prev_reg      <= '0;
            bar_cnt_reg   <= '0;
            rptr_reg      <= '0;
            vptr_reg      <= '0;
            rs_cnt_reg    <= '0;
            vcnt_reg      <= '0;
            left_reg      <= '0;
            p1_reg        <= 1'b0;
            p2_reg        <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            p1_reg    <= rd_en;
            p2_reg    <= p1_reg;

            if (cfg_valid)
            begin
                if (cfg_index == rvv_pkg::REG_VOL_WINDOW)
                    vol_win_reg <= cfg_data;
                else if (cfg_index == rvv_pkg::REG_VOV_WINDOW)
                    vov_win_reg <= cfg_data[rvv_pkg::VOVWIN_W-1:0];
            end

            if (rd_en)
                left_reg <= left_reg - 1'b1;

            if (state_reg == ST_RET)
            begin
                prev_reg <= price_reg;
                if (bar_cnt_reg != 2'd3)
                    bar_cnt_reg <= bar_cnt_reg + 1'b1;
                if (bar_cnt_reg != 2'd0)
                begin
                    rptr_reg   <= (rptr_reg == LAST_ADDR) ? '0 : rptr_reg + 1'b1;
                    rs_cnt_reg <= rs_cnt_new;
                end
                left_reg <= n_rsum;
            end

            if (state_reg == ST_WVOL)
            begin
                vptr_reg <= (vptr_reg == LAST_ADDR) ? '0 : vptr_reg + 1'b1;
                vcnt_reg <= vcnt_new;
                left_reg <= CW'(vc);
            end

            if (state_reg == ST_DIV2 && div_done)
                left_reg <= CW'(vc);

            if (state_reg == ST_DONE && (!m_tvalid_reg || m_tready))
                m_tvalid_reg <= 1'b1;
            else if (m_tvalid_reg && m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // datapath: addresses walk back from the newest entry
    always_ff @(posedge clk)
    begin
        if (accept)
            price_reg <= s_tdata & PRICE_MASK;

        if (state_reg == ST_RET)
        begin
            addr_reg      <= rptr_reg;
            acc_reg       <= '0;
            sat_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else if (state_reg == ST_WVOL)
        begin
            addr_reg <= vptr_reg;
            acc_reg  <= '0;
        end
        else if (state_reg == ST_DIV2 && div_done)
        begin
            addr_reg <= (vptr_reg == '0) ? LAST_ADDR : vptr_reg - 1'b1;
            mean_reg <= div_q[rvv_pkg::VOL_W-1:0];
            acc_reg  <= '0;
        end
        else if (rd_en)
        begin
            addr_reg <= (addr_reg == '0) ? LAST_ADDR : addr_reg - 1'b1;
        end

        if (p1_reg)
        begin
            if (state_reg == ST_DEV)
                val_reg <= dev_sq;
            else if (state_reg == ST_RSUM)
                val_reg <= rvv_pkg::VOV_W'(rs_rdata_reg);
            else
                val_reg <= rvv_pkg::VOV_W'(vh_rdata_reg);
        end

        if (p2_reg)
        begin
            acc_reg <= acc_sum[rvv_pkg::VOV_W-1:0];
            if (acc_sum[rvv_pkg::VOV_W])
                sat_reg <= 1'b1;
        end

        if (state_reg == ST_DEV && pass_end && !div_start)
        begin
            res_valid_reg <= 1'b1;
            res_reg       <= '1;
        end
        if (state_reg == ST_DIV3 && div_done)
        begin
            res_valid_reg <= 1'b1;
            res_reg       <= div_q;
        end

        if (state_reg == ST_DONE && (!m_tvalid_reg || m_tready))
        begin
            m_tuser_reg <= res_valid_reg;
            m_tdata_reg <= res_reg;
        end
    end

`ifndef SYNTHESIS
    a_vcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vcnt_reg <= DEPTH_CNT)
        else $error("vol count beyond history depth");

    a_rs_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rs_cnt_reg <= DEPTH_CNT && left_reg <= DEPTH_CNT)
        else $error("return fill or pass count beyond depth");

    a_accept_ret: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_RET)
        else $error("accepted bar did not start processing");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !m_tuser_reg) |-> m_tdata_reg == '0)
        else $error("invalid result carries nonzero vov");
`endif

endmodule
